FILE: src/ble_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared widths, constants, register indexes and divider control types.
// ----------------------------------------------------------------------------
package ble_pkg;

    localparam int MV_W    = 16;
    localparam int CUR_W   = 16;
    localparam int BAND_W  = 15;
    localparam int LVL_W   = 7;
    localparam int PCT_W   = 23;
    localparam int FRAC_W  = 16;
    localparam int HEAD_W  = PCT_W - FRAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int WINDOW_LEN_DEF = 8;

    localparam int PCT_STEPS = PCT_W;
    localparam int AVG_STEPS = HEAD_W;
    localparam int STEP_W    = $clog2(PCT_STEPS + 1);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100 * 65536);
    localparam logic [PCT_W-1:0] PCT_MUL  = PCT_W'(100);
    localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(100);

    localparam logic [MV_W-1:0]   EMPTY_RST = MV_W'(3300);
    localparam logic [MV_W-1:0]   FULL_RST  = MV_W'(4200);
    localparam logic [BAND_W-1:0] BAND_RST  = BAND_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_EMPTY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [PCT_W-1:0]  dq_init;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } t_div_sts;

endpackage

FILE: src/ble_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator input channel
// Valid/ready channel carrying one voltage and current sample or filter reset.
// ----------------------------------------------------------------------------
interface ble_in_if
    import ble_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic                    voltage_ok;
    logic [MV_W-1:0]         voltage_millivolts;
    logic                    current_ok;
    logic signed [CUR_W-1:0] current_milliamps;

    modport source (
        output valid, kind, voltage_ok, voltage_millivolts, current_ok,
               current_milliamps,
        input  ready
    );
    modport sink (
        input  valid, kind, voltage_ok, voltage_millivolts, current_ok,
               current_milliamps,
        output ready
    );
endinterface

FILE: src/ble_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator output channel
// Valid/ready channel carrying the smoothed level and charge direction flags.
// ----------------------------------------------------------------------------
interface ble_out_if
    import ble_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] level_percent;
    logic             is_charging;
    logic             is_discharging;

    modport source (
        output valid, level_percent, is_charging, is_discharging,
        input  ready
    );
    modport sink (
        input  valid, level_percent, is_charging, is_discharging,
        output ready
    );
endinterface

FILE: src/ble_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator shared divider
// Restoring divider, one quotient bit per cycle, preloaded partial remainder.
// ----------------------------------------------------------------------------
module ble_div
    import ble_pkg::*;
#(
    parameter int DV_W = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_div_ctl        i_ctl,
    input  logic [DV_W-1:0] i_rem_init,
    input  logic [DV_W-1:0] i_divisor,
    output t_div_sts        o_sts
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DV_W-1:0]   r_rem, n_rem;
    logic [DV_W-1:0]   r_div, n_div;
    logic [PCT_W-1:0]  r_dq, n_dq;
    logic [DV_W:0]     trial;
    logic [DV_W:0]     diff;

    always_comb begin
        trial  = {r_rem, r_dq[PCT_W-1]};
        diff   = trial - {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_dq   = r_dq;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = i_ctl.steps;
            n_rem  = i_rem_init;
            n_div  = i_divisor;
            n_dq   = i_ctl.dq_init;
        end else if (r_busy) begin
            if (!diff[DV_W]) begin
                n_rem = diff[DV_W-1:0];
                n_dq  = {r_dq[PCT_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DV_W-1:0];
                n_dq  = {r_dq[PCT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_dq  <= n_dq;
    end

    assign o_sts.done = r_done;
    assign o_sts.quot = r_dq;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("divider started while busy");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with no steps left");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without finishing a run");

endmodule

FILE: src/ble_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator history ring
// Single write, single registered read memory of level samples.
// ----------------------------------------------------------------------------
module ble_ring
    import ble_pkg::*;
#(
    parameter int DEPTH = WINDOW_LEN_DEF,
    parameter int IDX_W = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [PCT_W-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [PCT_W-1:0] o_rdata
);

    logic [PCT_W-1:0] mem [DEPTH];
    logic [PCT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/battery_level_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator
// Voltage to state-of-charge mapping with moving average and charge flags.
// ----------------------------------------------------------------------------
// One item is taken at a time. A filter reset or a sample with a failed
// voltage read is finished in the idle state. A sample whose voltage lies
// between the empty and full points uses the shared restoring divider twice:
// 23 steps for the voltage scaling and 7 steps for the rounded average. A
// voltage at or outside the end points skips the first division. The first
// sample after reset or a filter reset fills the whole history ring, one
// entry a cycle, in place of the single update. A finished result waits in
// the output register while the next item is taken.
// ----------------------------------------------------------------------------
module battery_level_estimator_unit
    import ble_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ble_in_if.sink                i_in,
    ble_out_if.source             o_out
);

    localparam int IDX_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOT_W     = PCT_W + $clog2(WINDOW_LEN);
    localparam int AVG_DIV   = WINDOW_LEN * 65536;
    localparam int AVG_BIAS  = WINDOW_LEN * 32768;
    localparam int AVG_DIV_W = $clog2(AVG_DIV + 1);
    localparam int DV_W      = (AVG_DIV_W > MV_W) ? AVG_DIV_W : MV_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAP    = 4'd1;
    localparam logic [3:0] S_PSTART = 4'd2;
    localparam logic [3:0] S_PWAIT  = 4'd3;
    localparam logic [3:0] S_PUSH   = 4'd4;
    localparam logic [3:0] S_UPD    = 4'd5;
    localparam logic [3:0] S_FILL   = 4'd6;
    localparam logic [3:0] S_ASTART = 4'd7;
    localparam logic [3:0] S_AWAIT  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [MV_W-1:0]   r_empty, n_empty;
    logic [MV_W-1:0]   r_full, n_full;
    logic [BAND_W-1:0] r_band, n_band;
    logic [MV_W-1:0]   r_mv, n_mv;
    logic              r_chg, n_chg;
    logic              r_dis, n_dis;
    logic [PCT_W-1:0]  r_prod, n_prod;
    logic [PCT_W-1:0]  r_pct, n_pct;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [IDX_W-1:0]  r_fill, n_fill;
    logic              r_primed, n_primed;
    logic              r_out_valid, n_out_valid;
    logic [LVL_W-1:0]  r_out_lvl, n_out_lvl;
    logic              r_out_chg, n_out_chg;
    logic              r_out_dis, n_out_dis;

    logic                    in_xfer;
    logic                    out_xfer;
    logic signed [CUR_W:0]   cur_ext;
    logic signed [CUR_W:0]   band_ext;
    logic signed [CUR_W:0]   band_neg;
    logic [MV_W-1:0]         mv_diff;
    logic [TOT_W-1:0]        avg_num;
    logic [LVL_W-1:0]        avg_q;
    t_div_ctl                div_ctl;
    t_div_sts                div_sts;
    logic [DV_W-1:0]         div_rem;
    logic [DV_W-1:0]         div_den;
    logic                    ring_we;
    logic [IDX_W-1:0]        ring_waddr;
    logic [PCT_W-1:0]        ring_rdata;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    assign cur_ext  = i_in.current_ok ?
                      {i_in.current_milliamps[CUR_W-1], i_in.current_milliamps} : '0;
    assign band_ext = $signed({2'b00, r_band});
    assign band_neg = -band_ext;
    assign mv_diff  = r_mv - r_empty;
    assign avg_num  = r_total + TOT_W'(AVG_BIAS);
    assign avg_q    = div_sts.quot[LVL_W-1:0];

    // divider request: top bits preload the remainder, low HEAD_W bits shift in
    always_comb begin
        div_ctl.start = (r_state == S_PSTART) || (r_state == S_ASTART);
        if (r_state == S_ASTART) begin
            div_ctl.steps   = STEP_W'(AVG_STEPS);
            div_ctl.dq_init = {avg_num[HEAD_W-1:0], {FRAC_W{1'b0}}};
            div_rem         = DV_W'(avg_num[TOT_W-1:HEAD_W]);
            div_den         = DV_W'(AVG_DIV);
        end else begin
            div_ctl.steps   = STEP_W'(PCT_STEPS);
            div_ctl.dq_init = {r_prod[HEAD_W-1:0], {FRAC_W{1'b0}}};
            div_rem         = DV_W'(r_prod[PCT_W-1:HEAD_W]);
            div_den         = DV_W'(r_full - r_empty);
        end
    end

    ble_div #(
        .DV_W (DV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_rem_init (div_rem),
        .i_divisor  (div_den),
        .o_sts      (div_sts)
    );

    assign ring_we    = (r_state == S_FILL) || (r_state == S_UPD);
    assign ring_waddr = (r_state == S_FILL) ? r_fill : r_slot;

    ble_ring #(
        .DEPTH (WINDOW_LEN),
        .IDX_W (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_pct),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_empty     = r_empty;
        n_full      = r_full;
        n_band      = r_band;
        n_mv        = r_mv;
        n_chg       = r_chg;
        n_dis       = r_dis;
        n_prod      = r_prod;
        n_pct       = r_pct;
        n_total     = r_total;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_primed    = r_primed;
        n_out_valid = r_out_valid;
        n_out_lvl   = r_out_lvl;
        n_out_chg   = r_out_chg;
        n_out_dis   = r_out_dis;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EMPTY: n_empty = i_cfg_data;
                REG_FULL:  n_full  = i_cfg_data;
                REG_BAND:  n_band  = i_cfg_data[BAND_W-1:0];
                default:   ;
            endcase
        end

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.kind) begin
                        n_total  = '0;
                        n_slot   = '0;
                        n_primed = 1'b0;
                    end else if (i_in.voltage_ok) begin
                        n_mv    = i_in.voltage_millivolts;
                        n_chg   = cur_ext > band_ext;
                        n_dis   = cur_ext < band_neg;
                        n_state = S_MAP;
                    end
                end
            end
            S_MAP: begin
                n_prod = PCT_W'(mv_diff) * PCT_MUL;
                if (r_mv >= r_full) begin
                    n_pct   = PCT_FULL;
                    n_state = S_PUSH;
                end else if (r_mv <= r_empty) begin
                    n_pct   = '0;
                    n_state = S_PUSH;
                end else begin
                    n_state = S_PSTART;
                end
            end
            S_PSTART: n_state = S_PWAIT;
            S_PWAIT: begin
                if (div_sts.done) begin
                    n_pct   = div_sts.quot;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_primed) begin
                    n_fill  = '0;
                    n_total = '0;
                    n_state = S_FILL;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_total = r_total - TOT_W'(ring_rdata) + TOT_W'(r_pct);
                n_slot  = (r_slot == IDX_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
                n_state = S_ASTART;
            end
            S_FILL: begin
                n_total = r_total + TOT_W'(r_pct);
                n_fill  = r_fill + 1'b1;
                if (r_fill == IDX_W'(WINDOW_LEN - 1)) begin
                    n_primed = 1'b1;
                    n_slot   = '0;
                    n_state  = S_ASTART;
                end
            end
            S_ASTART: n_state = S_AWAIT;
            S_AWAIT: begin
                if (div_sts.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_lvl   = (avg_q > LVL_MAX) ? LVL_MAX : avg_q;
                    n_out_chg   = r_chg;
                    n_out_dis   = r_dis;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_empty     <= EMPTY_RST;
            r_full      <= FULL_RST;
            r_band      <= BAND_RST;
            r_total     <= '0;
            r_slot      <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_empty     <= n_empty;
            r_full      <= n_full;
            r_band      <= n_band;
            r_total     <= n_total;
            r_slot      <= n_slot;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
        r_mv      <= n_mv;
        r_chg     <= n_chg;
        r_dis     <= n_dis;
        r_prod    <= n_prod;
        r_pct     <= n_pct;
        r_fill    <= n_fill;
        r_out_lvl <= n_out_lvl;
        r_out_chg <= n_out_chg;
        r_out_dis <= n_out_dis;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.level_percent  = r_out_lvl;
    assign o_out.is_charging    = r_out_chg;
    assign o_out.is_discharging = r_out_dis;

    a_fill_unprimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> !r_primed)
        else $error("ring fill while already primed");
    a_upd_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> r_primed)
        else $error("ring update before priming");
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_lvl <= LVL_MAX)
        else $error("level out of range");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_out_valid && !o_out.ready |=> r_state == S_DONE)
        else $error("result overwritten before transfer");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator testbench
// Runs a table of directed samples and filter resets, then random samples
// under several register settings, with random gaps on both channels. Each
// level result is checked field by field against an in-bench estimator that
// tracks the history ring, running total and thresholds.
// ----------------------------------------------------------------------------
module testbench
    import ble_pkg::*;
();

    localparam int  WINDOW        = WINDOW_LEN_DEF;
    localparam int  PHASE_ITEMS   = 140;
    localparam int  SETTLE_CYCLES = 60;
    localparam int  CYCLE_LIMIT   = 1500000;
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic                    voltage_ok;
        logic [MV_W-1:0]         millivolts;
        logic                    current_ok;
        logic [CUR_W-1:0]        milliamps;
    } t_sample;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             charging;
        logic             discharging;
    } t_level;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_sample               sample;
        bit                    pinned;
        t_level                want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ble_in_if  in_if();
    ble_out_if out_if();

    battery_level_estimator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // estimator state and register copies
    logic [MV_W-1:0]   empty_mv;
    logic [MV_W-1:0]   full_mv;
    logic [BAND_W-1:0] band_ma;
    logic [PCT_W-1:0]  soc_ring [WINDOW];
    logic [31:0]       soc_sum;
    int unsigned       ring_slot;
    bit                ring_primed;

    t_level level_q [$];
    t_row   plan [$];
    bit     pin_flag;
    t_level pin_level;
    int     accepted_count = 0;
    int     fail_count = 0;
    int     sender_calm = 0;

    function automatic bit estimate_step(input t_sample s, output t_level res);
        logic [PCT_W-1:0] pct;
        logic [63:0]      avg;
        int               cur;
        int               band;
        res = '0;
        if (s.kind == KIND_FLUSH) begin
            soc_sum = '0;
            ring_slot = 0;
            ring_primed = 1'b0;
            return 1'b0;
        end
        if (!s.voltage_ok) return 1'b0;
        if (s.millivolts >= full_mv) pct = PCT_FULL;
        else if (s.millivolts <= empty_mv) pct = '0;
        else pct = PCT_W'((64'(s.millivolts - empty_mv) * 64'd6553600) /
                          64'(full_mv - empty_mv));
        if (!ring_primed) begin
            for (int k = 0; k < WINDOW; k++) soc_ring[k] = pct;
            soc_sum = 32'(pct) * WINDOW;
            ring_slot = 0;
            ring_primed = 1'b1;
        end else begin
            soc_sum = soc_sum - 32'(soc_ring[ring_slot]) + 32'(pct);
            soc_ring[ring_slot] = pct;
            ring_slot = (ring_slot + 1) % WINDOW;
        end
        avg = (64'(soc_sum) + 64'(WINDOW) * 64'd32768) / (64'(WINDOW) * 64'd65536);
        if (avg > 64'(LVL_MAX)) avg = 64'(LVL_MAX);
        cur = s.current_ok ? int'($signed(s.milliamps)) : 0;
        band = int'(band_ma);
        res.level = LVL_W'(avg);
        res.charging = (cur > band);
        res.discharging = (cur < -band);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_sample random_sample(input int lo_mv, input int hi_mv,
                                              input int band);
        t_sample s;
        int r, v, c;
        r = $urandom_range(0, 99);
        s.kind = (r < 3) ? KIND_FLUSH : KIND_SAMPLE;
        s.voltage_ok = (r < 3 || r >= 8);
        s.current_ok = ($urandom_range(0, 9) != 0);
        r = $urandom_range(0, 99);
        if (r < 75) begin
            v = $urandom_range(hi_mv < 65515 ? hi_mv + 20 : 65535,
                               lo_mv > 20 ? lo_mv - 20 : 0);
        end else if (r < 90) begin
            case ($urandom_range(0, 3))
                0: v = lo_mv;
                1: v = hi_mv;
                2: v = lo_mv + 1;
                default: v = hi_mv - 1;
            endcase
        end else begin
            v = int'($urandom_range(0, 65535));
        end
        s.millivolts = MV_W'(v);
        r = $urandom_range(0, 99);
        if (r < 40) begin
            c = band + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) c = -c;
        end else if (r < 50) begin
            case ($urandom_range(0, 2))
                0: c = -32768;
                1: c = 32767;
                default: c = 0;
            endcase
        end else begin
            c = int'($urandom_range(0, 65535)) - 32768;
        end
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        s.milliamps = CUR_W'(c);
        return s;
    endfunction

    task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_row row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx = idx;
        row.data = CFG_DATA_W'(data);
        plan.push_back(row);
    endtask

    task automatic plan_item(input logic kind, input bit vok, input int mv,
                             input bit cok, input int cur, input bit pin,
                             input int lvl, input bit chg, input bit dis);
        t_row row;
        row = '{default: '0};
        row.sample = {kind, vok, MV_W'(mv), cok, CUR_W'(cur)};
        row.pinned = pin;
        row.want = {LVL_W'(lvl), chg, dis};
        plan.push_back(row);
    endtask

    task automatic offer(input t_sample s, input bit pin, input t_level want);
        in_if.valid <= 1'b1;
        in_if.kind <= s.kind;
        in_if.voltage_ok <= s.voltage_ok;
        in_if.voltage_millivolts <= s.millivolts;
        in_if.current_ok <= s.current_ok;
        in_if.current_milliamps <= s.milliamps;
        pin_flag <= pin;
        pin_level <= want;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic idle_sender();
        int gap;
        if (sender_calm > 0) begin
            sender_calm--;
            return;
        end
        if ($urandom_range(0, 99) < 2) begin
            sender_calm = $urandom_range(20, 150);
            return;
        end
        gap = ($urandom_range(0, 99) < 55) ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        @(posedge i_clk);
    endtask

    // scoreboard: register copies, predictions on input transfers, checks
    // on output transfers
    always @(posedge i_clk) begin : scoreboard
        t_sample s;
        t_level  want;
        if (!i_rst_n) begin
            empty_mv = EMPTY_RST;
            full_mv = FULL_RST;
            band_ma = BAND_RST;
            soc_sum = '0;
            ring_slot = 0;
            ring_primed = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_EMPTY: empty_mv = i_cfg_data[MV_W-1:0];
                    REG_FULL:  full_mv = i_cfg_data[MV_W-1:0];
                    REG_BAND:  band_ma = i_cfg_data[BAND_W-1:0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                accepted_count++;
                s = {in_if.kind, in_if.voltage_ok, in_if.voltage_millivolts,
                     in_if.current_ok, in_if.current_milliamps};
                if (estimate_step(s, want)) begin
                    if (pin_flag) want = pin_level;
                    level_q.push_back(want);
                end
            end
            if (out_if.valid && out_if.ready) begin
                if (level_q.size() == 0) begin
                    $display("%0t: unexpected transfer: level %0d chg %0b dis %0b", $time,
                             out_if.level_percent, out_if.is_charging,
                             out_if.is_discharging);
                    fail_count++;
                end else begin
                    want = level_q.pop_front();
                    if (out_if.level_percent !== want.level) begin
                        $display("%0t: level_percent expected %0d, got %0d", $time,
                                 want.level, out_if.level_percent);
                        fail_count++;
                    end
                    if (out_if.is_charging !== want.charging) begin
                        $display("%0t: is_charging expected %0b, got %0b", $time,
                                 want.charging, out_if.is_charging);
                        fail_count++;
                    end
                    if (out_if.is_discharging !== want.discharging) begin
                        $display("%0t: is_discharging expected %0b, got %0b", $time,
                                 want.discharging, out_if.is_discharging);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result side: random gaps, calm stretches, and long hold-offs
    initial begin : ready_driver
        int calm;
        int hold_mark;
        int r;
        calm = 0;
        hold_mark = 400;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (accepted_count >= hold_mark) begin
                hold_mark += 800;
                out_if.ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end else if (calm > 0) begin
                calm--;
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else if (r < 3) begin
                calm = $urandom_range(30, 300);
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else if (r < 28) begin
                out_if.ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        t_sample s;
        bit      writing;
        bit      paused;
        int      counted;
        int      e, f, b;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.kind <= KIND_SAMPLE;
        in_if.voltage_ok <= 1'b0;
        in_if.voltage_millivolts <= '0;
        in_if.current_ok <= 1'b0;
        in_if.current_milliamps <= '0;
        pin_flag <= 1'b0;
        pin_level <= '0;

        // default thresholds 3300 / 4200 mV, deadband 5 mA
        plan_item(KIND_FLUSH,  1, 4200,  1, 0,      0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 0, 4200,  1, 0,      0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 4200,  1, 32767,  1, 100, 1, 0);
        plan_item(KIND_SAMPLE, 1, 65535, 1, -32768, 1, 100, 0, 1);
        plan_item(KIND_SAMPLE, 1, 3300,  1, 5,      0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 3301,  1, -5,     0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 4199,  0, 6,      0, 0,   0, 0);
        plan_item(KIND_FLUSH,  0, 0,     0, -6,     0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 0,     1, -6,     1, 0,   0, 1);
        plan_item(KIND_SAMPLE, 1, 3750,  1, 0,      0, 0,   0, 0);
        plan_item(KIND_FLUSH,  1, 65535, 1, 32767,  0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 3750,  1, 6,      1, 50,  1, 0);
        plan_item(KIND_SAMPLE, 0, 0,     1, 100,    0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 3525,  0, -32768, 0, 0,   0, 0);
        // empty above full: full test wins
        plan_write(REG_BAND, 32767);
        plan_write(REG_EMPTY, 65535);
        plan_write(REG_FULL, 0);
        plan_item(KIND_FLUSH,  1, 0,     1, 0,      0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 0,     1, 32767,  1, 100, 0, 0);
        plan_item(KIND_SAMPLE, 1, 65535, 1, -32768, 1, 100, 0, 1);
        // empty equal to full, zero deadband
        plan_write(REG_EMPTY, 1000);
        plan_write(REG_FULL, 1000);
        plan_write(REG_BAND, 0);
        plan_item(KIND_FLUSH,  1, 0,     1, 0,      0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 999,   1, 1,      1, 0,   1, 0);
        plan_item(KIND_SAMPLE, 1, 1000,  1, -1,     0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 1000,  1, 0,      0, 0,   0, 0);
        // widest span
        plan_write(REG_EMPTY, 0);
        plan_write(REG_FULL, 65535);
        plan_item(KIND_FLUSH,  1, 0,     1, 0,      0, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 1,     1, 0,      1, 0,   0, 0);
        plan_item(KIND_SAMPLE, 1, 65534, 1, 0,      0, 0,   0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        writing = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                if (!writing) wait_idle();
                write_reg(plan[i].idx, int'(plan[i].data));
                writing = 1'b1;
            end else begin
                if (writing) i_cfg_we <= 1'b0;
                writing = 1'b0;
                offer(plan[i].sample, plan[i].pinned, plan[i].want);
                idle_sender();
            end
        end

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin e = 0;     f = 65535; b = 0;     end
                1: begin e = 65535; f = 0;     b = 32767; end
                2: begin e = 2000;  f = 2000;  b = 1;     end
                3: begin e = 3000;  f = 3001;  b = 100;   end
                4: begin e = 65534; f = 65535; b = 32766; end
                5: begin e = 0;     f = 1;     b = 0;     end
                6, 7, 8: begin
                    e = $urandom_range(0, 60000);
                    f = e + int'($urandom_range(1, 65535 - e));
                    b = $urandom_range(0, 32767);
                end
                default: begin e = 3300; f = 4200; b = 5; end
            endcase
            wait_idle();
            write_reg(REG_EMPTY, e);
            write_reg(REG_FULL, f);
            write_reg(REG_BAND, b);
            i_cfg_we <= 1'b0;
            counted = 0;
            paused = 1'b0;
            while (counted < PHASE_ITEMS) begin
                s = random_sample(e < f ? e : f, e < f ? f : e, b);
                offer(s, 1'b0, '0);
                if (s.kind == KIND_SAMPLE && s.voltage_ok) counted++;
                if (!paused && counted >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    wait_idle();
                end else begin
                    idle_sender();
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && level_q.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/ble_pkg.sv
src/ble_in_if.sv
src/ble_out_if.sv
src/ble_div.sv
src/ble_ring.sv
src/battery_level_estimator_unit.sv
tb/sv/testbench.sv
